FILE: rtl/vadpcm_frame_decoder_macros.svh
// ----------------------------------------------------------------------------
// vadpcm_frame_decoder_macros.svh
// Assertion macros shared by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef VADPCM_FRAME_DECODER_MACROS_SVH
`define VADPCM_FRAME_DECODER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled in reset
`define VFD_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled in reset
`define VFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define VFD_ASSERT(label, clk, rst_n, ante, cons)
`define VFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/vadpcm_pkg.sv
// ----------------------------------------------------------------------------
// vadpcm_pkg
// Shared constants, command codes and queue word types of the frame decoder.
// ----------------------------------------------------------------------------
package vadpcm_pkg;

	localparam int NUM_PREDICTORS_DEF = 8;

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	// Command codes
	localparam logic [1:0] CMD_LOAD_COEF = 2'd0;
	localparam logic [1:0] CMD_LOAD_LOOP = 2'd1;
	localparam logic [1:0] CMD_DECODE    = 2'd2;

	// Start modes of a decode
	localparam logic [1:0] MODE_CONT = 2'd0;
	localparam logic [1:0] MODE_ZERO = 2'd1;
	localparam logic [1:0] MODE_LOOP = 2'd2;

	typedef struct packed {
		logic [1:0]         op;
		logic [1:0]         mode;
		logic [3:0]         shift;
		logic [3:0]         pred;
		logic [63:0]        data;
		logic [6:0]         cidx;
		logic signed [15:0] cval;
		logic signed [15:0] loop_last;
		logic signed [15:0] loop_before_last;
	} cmd_word_t;

	typedef struct packed {
		logic      valid;
		cmd_word_t word;
	} q_head_t;

endpackage

FILE: rtl/vadpcm_frame_decoder.sv
// ----------------------------------------------------------------------------
// vadpcm_frame_decoder
// Order-2 ADPCM frame decoder: codebook and loop-history loads, and decode of
// 9-byte frames into sixteen clamped 16-bit samples.
//
// Channel  Handshake                 Payload
// cmd      cmd_valid / cmd_stall     command, start_mode, frame_header,
//                                    frame_data, coef_index, coef_value,
//                                    loop_last, loop_before_last
// sample   sample_valid / sample_stall  sample, last
//
// A load command is executed as it is taken from the queue. A decode takes it
// from the queue, then runs 88 multiply-accumulate terms through the one shared
// multiplier, one term per cycle while the pipeline is not frozen, and a pipeline
// drain after each half-frame for the history.
// Reset clears the codebook valid bits at once; there is no clearing pass.
// sample_stall freezes the decode pipeline while a sample is held; the two-word command queue keeps
// accepting until it is full.
// ----------------------------------------------------------------------------
module vadpcm_frame_decoder import vadpcm_pkg::*; #(
	parameter int NUM_PREDICTORS = NUM_PREDICTORS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         command,
	input  logic [1:0]         start_mode,
	input  logic [7:0]         frame_header,
	input  logic [63:0]        frame_data,
	input  logic [6:0]         coef_index,
	input  logic signed [15:0] coef_value,
	input  logic signed [15:0] loop_last,
	input  logic signed [15:0] loop_before_last,
	output logic               sample_valid,
	input  logic               sample_stall,
	output logic signed [15:0] sample,
	output logic               last
);

	q_head_t head;
	logic    pop;

	// Front: accept, classify, queue
	vadpcm_front #(
		.NUM_PREDICTORS(NUM_PREDICTORS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_stall       (cmd_stall),
		.command         (command),
		.start_mode      (start_mode),
		.frame_header    (frame_header),
		.frame_data      (frame_data),
		.coef_index      (coef_index),
		.coef_value      (coef_value),
		.loop_last       (loop_last),
		.loop_before_last(loop_before_last),
		.head            (head),
		.pop             (pop)
	);

	// Back: execute and emit samples
	vadpcm_back #(
		.NUM_PREDICTORS(NUM_PREDICTORS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.last        (last)
	);

endmodule

FILE: rtl/vadpcm_ram.sv
// ----------------------------------------------------------------------------
// vadpcm_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module vadpcm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, hold while disabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/vadpcm_front.sv
// ----------------------------------------------------------------------------
// vadpcm_front
// Accepts command words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`include "vadpcm_frame_decoder_macros.svh"

module vadpcm_front import vadpcm_pkg::*; #(
	parameter int NUM_PREDICTORS = NUM_PREDICTORS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         command,
	input  logic [1:0]         start_mode,
	input  logic [7:0]         frame_header,
	input  logic [63:0]        frame_data,
	input  logic [6:0]         coef_index,
	input  logic signed [15:0] coef_value,
	input  logic signed [15:0] loop_last,
	input  logic signed [15:0] loop_before_last,
	output q_head_t            head,
	input  logic               pop
);

	cmd_word_t      q_mem [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic [3:0]     pred_tab [16];
	logic           known_cmd;
	logic           push;
	cmd_word_t      word_in;

	// Predictor number folded into the codebook range
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			pred_tab[i] = 4'(i % NUM_PREDICTORS);
		end
	end

	// Classify the incoming word
	always_comb begin
		known_cmd = (command inside {CMD_LOAD_COEF, CMD_LOAD_LOOP, CMD_DECODE});
		word_in.op = command;
		case (start_mode)
			MODE_ZERO: word_in.mode = MODE_ZERO;
			MODE_LOOP: word_in.mode = MODE_LOOP;
			default:   word_in.mode = MODE_CONT;
		endcase
		word_in.shift            = frame_header[7:4];
		word_in.pred             = pred_tab[frame_header[3:0]];
		word_in.data             = frame_data;
		word_in.cidx             = coef_index;
		word_in.cval             = coef_value;
		word_in.loop_last        = loop_last;
		word_in.loop_before_last = loop_before_last;
	end

	// Unknown commands are taken and dropped
	assign cmd_stall = (count_q == (QAW+1)'(QDEPTH));
	assign push      = cmd_valid && !cmd_stall && known_cmd;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= word_in;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head.valid = (count_q != '0);
	assign head.word  = q_mem[rd_ptr_q];

	`VFD_ASSERT(a_count_bound, clk, arst_n, 1'b1, count_q <= (QAW+1)'(QDEPTH))
	`VFD_ASSERT(a_pop_nonempty, clk, arst_n, count_q == '0, !pop)
	`VFD_ASSERT_NEXT(a_full_hold, clk, arst_n, cmd_stall && !pop, cmd_stall)

endmodule

FILE: rtl/vadpcm_back.sv
// ----------------------------------------------------------------------------
// vadpcm_back
// Executes queued commands: codebook and loop loads, and frame decode through
// a sequencer driving one shared multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
`include "vadpcm_frame_decoder_macros.svh"

module vadpcm_back import vadpcm_pkg::*; #(
	parameter int NUM_PREDICTORS = NUM_PREDICTORS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  q_head_t            head,
	output logic               pop,
	output logic               sample_valid,
	input  logic               sample_stall,
	output logic signed [15:0] sample,
	output logic               last
);

	localparam int BOOK_WORDS = NUM_PREDICTORS * 16;
	localparam int AW         = $clog2(BOOK_WORDS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	// Nibble at position pos, first nibble in the top bits
	function automatic logic [3:0] nibble_at(input logic [63:0] d, input logic [3:0] pos);
		logic [3:0] sel;
		sel = 4'd15 - pos;
		return d[{sel, 2'b00} +: 4];
	endfunction

	// Sign-extend, shift left, wrap to 16 bits
	function automatic logic [15:0] residual(input logic [3:0] nib, input logic [3:0] sh);
		logic [15:0] ext;
		ext = {{12{nib[3]}}, nib};
		return ext << sh;
	endfunction

	// Arithmetic shift right by 11 and clamp to 16 bits
	function automatic logic [15:0] asr_clamp(input logic [31:0] acc);
		logic fits;
		fits = (acc[31:26] == {6{acc[31]}});
		if (fits) begin
			return acc[26:11];
		end
		return acc[31] ? 16'h8000 : 16'h7fff;
	endfunction

	logic [1:0]            state_q;
	logic                  half_q;
	logic [2:0]            j_q;
	logic [3:0]            t_q;
	logic [3:0]            shift_q;
	logic [AW-1:0]         base_q;
	logic [63:0]           data_q;
	logic signed [15:0]    hist_last_q;
	logic signed [15:0]    hist_before_last_q;
	logic signed [15:0]    loop_last_q;
	logic signed [15:0]    loop_before_last_q;
	logic signed [15:0]    got6_q;
	logic signed [15:0]    got7_q;
	logic [BOOK_WORDS-1:0] cb_valid_q;

	logic                  adv;
	logic                  issue;
	logic                  last_term;
	logic                  pipe_empty;
	logic [2:0]            k;
	logic [3:0]            off;
	logic signed [15:0]    opnd;
	logic [15:0]           res_k;
	logic [15:0]           res_j;
	logic [AW-1:0]         rd_addr;
	logic                  cb_we;
	logic [AW-1:0]         cb_waddr;
	logic [15:0]           cb_rdata;
	logic signed [15:0]    coef;

	logic                  v_s1;
	logic                  first_s1;
	logic                  last_s1;
	logic [3:0]            idx_s1;
	logic signed [15:0]    opnd_s1;
	logic [15:0]           resj_s1;
	logic                  cbv_s1;

	logic                  v_s2;
	logic                  first_s2;
	logic                  last_s2;
	logic [3:0]            idx_s2;
	logic signed [31:0]    prod_s2;
	logic [15:0]           resj_s2;

	logic [31:0]           acc_q;
	logic                  done_s3;
	logic [3:0]            idx_s3;

	logic                  out_valid_q;
	logic [15:0]           sample_q;
	logic                  last_q;

	// Pipeline moves unless a finished sample is held by the sink
	assign adv        = !(out_valid_q && sample_stall);
	assign pop        = (state_q == ST_IDLE) && head.valid;
	assign issue      = (state_q == ST_ISSUE);
	assign last_term  = (t_q == ({1'b0, j_q} + 4'd1));
	assign pipe_empty = !v_s1 && !v_s2 && !done_s3;

	// Select coefficient address and operand of the current term
	always_comb begin
		k     = 3'(t_q - 4'd2);
		res_k = residual(nibble_at(data_q, {half_q, k}), shift_q);
		res_j = residual(nibble_at(data_q, {half_q, j_q}), shift_q);
		if (t_q == 4'd0) begin
			off  = {1'b0, j_q};
			opnd = hist_before_last_q;
		end else if (t_q == 4'd1) begin
			off  = {1'b1, j_q};
			opnd = hist_last_q;
		end else begin
			off  = {1'b1, 3'(j_q - k - 3'd1)};
			opnd = $signed(res_k);
		end
		rd_addr = base_q + AW'(off);
	end

	// Codebook load from the queue head; out-of-range addresses drop
	assign cb_we    = pop && (head.word.op == CMD_LOAD_COEF) &&
	                  (32'(head.word.cidx) < BOOK_WORDS);
	assign cb_waddr = AW'(head.word.cidx);

	vadpcm_ram #(
		.WIDTH(16),
		.DEPTH(BOOK_WORDS)
	) u_codebook (
		.clk  (clk),
		.we   (cb_we),
		.waddr(cb_waddr),
		.wdata(head.word.cval),
		.re   (adv),
		.raddr(rd_addr),
		.rdata(cb_rdata)
	);

	// Never-written words read as zero
	assign coef = cbv_s1 ? $signed(cb_rdata) : 16'sd0;

	// Sequencer and history state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_IDLE;
			half_q             <= 1'b0;
			j_q                <= '0;
			t_q                <= '0;
			hist_last_q        <= '0;
			hist_before_last_q <= '0;
			loop_last_q        <= '0;
			loop_before_last_q <= '0;
			cb_valid_q         <= '0;
		end else begin
			if (cb_we) begin
				cb_valid_q[cb_waddr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						case (head.word.op)
							CMD_LOAD_LOOP: begin
								loop_last_q        <= head.word.loop_last;
								loop_before_last_q <= head.word.loop_before_last;
							end
							CMD_DECODE: begin
								if (head.word.mode == MODE_ZERO) begin
									hist_last_q        <= '0;
									hist_before_last_q <= '0;
								end else if (head.word.mode == MODE_LOOP) begin
									hist_last_q        <= loop_last_q;
									hist_before_last_q <= loop_before_last_q;
								end
								half_q  <= 1'b0;
								j_q     <= '0;
								t_q     <= '0;
								state_q <= ST_ISSUE;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ISSUE: begin
					if (adv) begin
						if (last_term) begin
							t_q <= '0;
							j_q <= j_q + 3'd1;
							if (j_q == 3'd7) begin
								state_q <= ST_DRAIN;
							end
						end else begin
							t_q <= t_q + 4'd1;
						end
					end
				end
				ST_DRAIN: begin
					// Half done: its last two samples become the history
					if (pipe_empty) begin
						hist_last_q        <= got7_q;
						hist_before_last_q <= got6_q;
						if (!half_q) begin
							half_q  <= 1'b1;
							j_q     <= '0;
							t_q     <= '0;
							state_q <= ST_ISSUE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch frame payload at decode start
	always_ff @(posedge clk) begin
		if (pop && (head.word.op == CMD_DECODE)) begin
			shift_q <= head.word.shift;
			base_q  <= AW'({head.word.pred, 4'b0000});
			data_q  <= head.word.data;
		end
	end

	// Pipeline valid flags and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			done_s3     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			done_s3     <= v_s2 && last_s2;
			out_valid_q <= done_s3;
		end
	end

	// Pipeline payload: fetch, multiply, accumulate, clamp
	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1 <= (t_q == 4'd0);
			last_s1  <= last_term;
			idx_s1   <= {half_q, j_q};
			opnd_s1  <= opnd;
			resj_s1  <= res_j;
			cbv_s1   <= cb_valid_q[rd_addr];

			first_s2 <= first_s1;
			last_s2  <= last_s1;
			idx_s2   <= idx_s1;
			resj_s2  <= resj_s1;
			prod_s2  <= 32'(coef) * 32'(opnd_s1);

			if (v_s2) begin
				if (first_s2) begin
					acc_q <= {{5{resj_s2[15]}}, resj_s2, 11'b0} + prod_s2;
				end else begin
					acc_q <= acc_q + prod_s2;
				end
				if (last_s2) begin
					idx_s3 <= idx_s2;
				end
			end

			if (done_s3) begin
				sample_q <= asr_clamp(acc_q);
				last_q   <= (idx_s3 == 4'd15);
				if (idx_s3[2:0] == 3'd6) begin
					got6_q <= $signed(asr_clamp(acc_q));
				end
				if (idx_s3[2:0] == 3'd7) begin
					got7_q <= $signed(asr_clamp(acc_q));
				end
			end
		end
	end

	assign sample_valid = out_valid_q;
	assign sample       = $signed(sample_q);
	assign last         = last_q;

	`VFD_ASSERT(a_idle_empty, clk, arst_n, state_q == ST_IDLE, pipe_empty)
	`VFD_ASSERT(a_term_bound, clk, arst_n, state_q == ST_ISSUE, t_q <= ({1'b0, j_q} + 4'd1))
	`VFD_ASSERT_NEXT(a_freeze, clk, arst_n, sample_valid && sample_stall, $stable(acc_q) && $stable(done_s3))

endmodule
